// File: hdl/lfdc_pkg.sv
package lfdc_pkg;

    // Fixed shape of the sensor bar and of the payload fields.
    localparam int SENSOR_NUM = 8;
    localparam int SENSOR_W   = 10;
    localparam int POS_W      = 13;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 8;
    localparam int WHEEL_W    = 9;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Widths of the controller arithmetic.
    localparam int ERR_W    = 15;
    localparam int DIFF_W   = 16;
    localparam int SUM_W    = 32;
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int CORR_W   = PROD_I_W + 1;
    localparam int NUM_W    = CORR_W + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_CENTER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_LEVEL     = 3'd7;

    // Bits of drive_mode.
    localparam int MODE_BANG_BIT = 0;
    localparam int MODE_ARM_BIT  = 1;

    localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd230;
    localparam int                 SPEED_MAX      = 255;

    typedef logic [SENSOR_W-1:0] t_sensor;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [MODE_W-1:0]   drive_mode;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [POS_W-1:0]    line_center;
        logic [SPEED_W-1:0]  base_speed;
        logic [SENSOR_W-1:0] line_threshold;
        logic [SENSOR_W-1:0] lost_level;
    } t_cfg;

    // One classified sample on its way from the front to the back.
    // A word with is_pid clear carries its final wheel commands.
    typedef struct packed {
        logic                is_pid;
        logic [WHEEL_W-1:0]  left;
        logic [WHEEL_W-1:0]  right;
        logic                brake;
        logic                lost;
        logic [ERR_W-1:0]    err;
        logic [DIFF_W-1:0]   diff;
        logic [SUM_W-1:0]    acc;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// File: hdl/lfdc_fifo.sv
module lfdc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lfdc_pkg::t_entry      i_data,
    input  logic                  i_pop,
    output lfdc_pkg::t_entry      o_head,
    output lfdc_pkg::t_fifo_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfdc_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// File: hdl/lfdc_front.sv
module lfdc_front (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  lfdc_pkg::t_cfg                                   i_cfg,
    input  logic                                             i_valid,
    input  lfdc_pkg::t_sensor [lfdc_pkg::SENSOR_NUM-1:0]     i_sensor,
    input  logic [lfdc_pkg::POS_W-1:0]                       i_line_position,
    input  logic                                             i_full,
    output logic                                             o_push,
    output lfdc_pkg::t_entry                                 o_entry
);

    logic signed [lfdc_pkg::SUM_W-1:0] r_error_sum, n_error_sum;
    logic signed [lfdc_pkg::ERR_W-1:0] r_last_error;

    logic [lfdc_pkg::WHEEL_W-1:0]      w_sl, w_nsl;
    logic [lfdc_pkg::SENSOR_W-1:0]     w_t, w_ll;
    logic                              w_bang, w_hit_mid, w_hit_right, w_hit_left;
    logic                              w_lost, w_last_pos;
    logic signed [lfdc_pkg::ERR_W-1:0] w_err;
    logic signed [lfdc_pkg::SUM_W:0]   w_sum_wide;
    logic signed [lfdc_pkg::DIFF_W-1:0] w_diff;
    logic                              w_pid_update;

    // Spin speeds and sensor group compares.
    always_comb begin
        w_sl  = {1'b0, i_cfg.base_speed};
        w_nsl = ~w_sl + lfdc_pkg::WHEEL_W'(1);
        w_t   = i_cfg.line_threshold;
        w_ll  = i_cfg.lost_level;
        w_bang = i_cfg.drive_mode[lfdc_pkg::MODE_BANG_BIT];

        w_hit_mid   = (i_sensor[3] > w_t) || (i_sensor[4] > w_t);
        w_hit_right = (i_sensor[5] > w_t) || (i_sensor[6] > w_t) || (i_sensor[7] > w_t);
        w_hit_left  = (i_sensor[0] > w_t) || (i_sensor[1] > w_t) || (i_sensor[2] > w_t);

        w_lost     = (i_sensor[3] <= w_ll) && (i_sensor[4] <= w_ll);
        w_last_pos = !r_last_error[lfdc_pkg::ERR_W-1] && (r_last_error != '0);
    end

    // Error, saturating integral and difference for the PID path.
    always_comb begin
        w_err = $signed({2'b00, i_cfg.line_center}) - $signed({2'b00, i_line_position});
        w_sum_wide = $signed({r_error_sum[lfdc_pkg::SUM_W-1], r_error_sum})
                   + $signed({{(lfdc_pkg::SUM_W + 1 - lfdc_pkg::ERR_W){w_err[lfdc_pkg::ERR_W-1]}},
                              w_err});
        if (w_sum_wide[lfdc_pkg::SUM_W] != w_sum_wide[lfdc_pkg::SUM_W-1]) begin
            // Overflow: clamp to the signed 32-bit limit on the side of the true sign.
            n_error_sum = w_sum_wide[lfdc_pkg::SUM_W]
                        ? {1'b1, {(lfdc_pkg::SUM_W - 1){1'b0}}}
                        : {1'b0, {(lfdc_pkg::SUM_W - 1){1'b1}}};
        end else begin
            n_error_sum = w_sum_wide[lfdc_pkg::SUM_W-1:0];
        end
        w_diff = $signed({w_err[lfdc_pkg::ERR_W-1], w_err})
               - $signed({r_last_error[lfdc_pkg::ERR_W-1], r_last_error});
    end

    // Classify the sample and build the queue word.
    always_comb begin
        o_entry        = '0;
        o_entry.brake  = !i_cfg.drive_mode[lfdc_pkg::MODE_ARM_BIT];
        o_entry.err    = w_err;
        o_entry.diff   = w_diff;
        o_entry.acc    = n_error_sum;
        priority if (w_bang) begin
            priority if (w_hit_mid) begin
                o_entry.left  = w_sl;
                o_entry.right = w_sl;
            end else if (w_hit_right) begin
                o_entry.left  = w_sl;
                o_entry.right = w_nsl;
            end else if (w_hit_left || (i_line_position < i_cfg.line_center)) begin
                o_entry.left  = w_nsl;
                o_entry.right = w_sl;
            end else begin
                o_entry.left  = w_sl;
                o_entry.right = w_nsl;
            end
        end else if (w_lost) begin
            o_entry.lost  = 1'b1;
            o_entry.left  = w_last_pos ? w_nsl : w_sl;
            o_entry.right = w_last_pos ? w_sl : w_nsl;
        end else begin
            o_entry.is_pid = 1'b1;
        end
    end

    assign o_push       = i_valid && !i_full;
    assign w_pid_update = o_push && o_entry.is_pid;

    // Controller state moves only on an accepted PID sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (w_pid_update) begin
            r_error_sum  <= n_error_sum;
            r_last_error <= w_err;
        end
    end

endmodule

// File: hdl/lfdc_back.sv
module lfdc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lfdc_pkg::t_cfg                     i_cfg,
    input  lfdc_pkg::t_entry                   i_head,
    input  lfdc_pkg::t_fifo_status             i_status,
    output logic                               o_pop,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic [lfdc_pkg::WHEEL_W-1:0]       o_left,
    output logic [lfdc_pkg::WHEEL_W-1:0]       o_right,
    output logic                               o_brake,
    output logic                               o_lost
);

    localparam int QUOT_W = lfdc_pkg::NUM_W - 8;

    // Truncating divide by 256 followed by the out-of-range substitution.
    function automatic logic [lfdc_pkg::WHEEL_W-1:0] fit_speed(
        input logic signed [lfdc_pkg::NUM_W-1:0] num,
        input logic [lfdc_pkg::WHEEL_W-1:0]      sl,
        input logic [lfdc_pkg::WHEEL_W-1:0]      nsl
    );
        logic signed [lfdc_pkg::NUM_W-1:0] adj;
        logic signed [QUOT_W-1:0]          quot;
        adj  = num + (num[lfdc_pkg::NUM_W-1] ? lfdc_pkg::NUM_W'(255) : '0);
        quot = QUOT_W'(adj >>> 8);
        if (quot > $signed(QUOT_W'(lfdc_pkg::SPEED_MAX))) begin
            return sl;
        end else if (quot < -$signed(QUOT_W'(lfdc_pkg::SPEED_MAX))) begin
            return nsl;
        end
        return quot[lfdc_pkg::WHEEL_W-1:0];
    endfunction

    logic w_adv;

    logic                                  r_s1_valid;
    lfdc_pkg::t_entry                      r_s1_ent;
    logic signed [lfdc_pkg::PROD_P_W-1:0]  r_prod_p, n_prod_p;
    logic signed [lfdc_pkg::PROD_I_W-1:0]  r_prod_i, n_prod_i;
    logic signed [lfdc_pkg::PROD_D_W-1:0]  r_prod_d, n_prod_d;

    logic                                  r_s2_valid;
    lfdc_pkg::t_entry                      r_s2_ent;
    logic signed [lfdc_pkg::CORR_W-1:0]    r_corr, n_corr;

    logic                                  r_out_valid;
    logic [lfdc_pkg::WHEEL_W-1:0]          r_left, r_right;
    logic                                  r_brake, r_lost;

    logic [lfdc_pkg::WHEEL_W-1:0]          w_sl, w_nsl;
    logic signed [lfdc_pkg::NUM_W-1:0]     w_base, w_corr_ext, w_left_num, w_right_num;

    // The whole pipeline moves when the output word is free or being taken.
    assign w_adv = !r_out_valid || !i_stall;
    assign o_pop = w_adv && !i_status.empty;

    // Stage one: the three gain products.
    always_comb begin
        n_prod_p = $signed({1'b0, i_cfg.gain_p}) * $signed(i_head.err);
        n_prod_i = $signed({1'b0, i_cfg.gain_i}) * $signed(i_head.acc);
        n_prod_d = $signed({1'b0, i_cfg.gain_d}) * $signed(i_head.diff);
    end

    // Stage two: the correction sum.
    always_comb begin
        n_corr = $signed({r_prod_i[lfdc_pkg::PROD_I_W-1], r_prod_i})
               + $signed({{(lfdc_pkg::CORR_W - lfdc_pkg::PROD_P_W){r_prod_p[lfdc_pkg::PROD_P_W-1]}},
                          r_prod_p})
               + $signed({{(lfdc_pkg::CORR_W - lfdc_pkg::PROD_D_W){r_prod_d[lfdc_pkg::PROD_D_W-1]}},
                          r_prod_d});
    end

    // Stage three: wheel numerators around the base speed.
    always_comb begin
        w_sl        = {1'b0, i_cfg.base_speed};
        w_nsl       = ~w_sl + lfdc_pkg::WHEEL_W'(1);
        w_base      = $signed({{(lfdc_pkg::NUM_W - lfdc_pkg::SPEED_W - 8){1'b0}},
                               i_cfg.base_speed, 8'h00});
        w_corr_ext  = $signed({r_corr[lfdc_pkg::CORR_W-1], r_corr});
        w_left_num  = w_base - w_corr_ext;
        w_right_num = w_base + w_corr_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Payload registers follow the valid bits.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ent <= i_head;
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_s2_ent <= r_s1_ent;
            r_corr   <= n_corr;
            if (r_s2_valid) begin
                r_brake <= r_s2_ent.brake;
                r_lost  <= r_s2_ent.lost;
                if (r_s2_ent.is_pid) begin
                    r_left  <= fit_speed(w_left_num, w_sl, w_nsl);
                    r_right <= fit_speed(w_right_num, w_sl, w_nsl);
                end else begin
                    r_left  <= r_s2_ent.left;
                    r_right <= r_s2_ent.right;
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_brake = r_brake;
    assign o_lost  = r_lost;

endmodule

// File: hdl/line_follow_drive_controller_top.sv
// Line follower drive controller. Each input word is one sensor bar sample (eight
// calibrated readings and a line position); each output word is a pair of signed
// wheel commands with brake and line-lost flags. The block takes one word per
// clock while its queue is not full: the front classifies a sample and, for a
// PID sample, updates the PID integral and last error in the cycle it is accepted;
// the back turns it into wheel speeds in a three-stage pipeline (gain multiplies,
// correction sum, divide and limit). A FIFO_DEPTH-word queue sits between the
// two, so input stall rises only when that queue is full; an accepted sample is
// written into it and then passes the stage one, stage two and output registers.
// Configuration writes take effect at once and are meant for idle periods.
module line_follow_drive_controller_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_wr_en,
    input  logic [lfdc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lfdc_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_0,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_1,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_2,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_3,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_4,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_5,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_6,
    input  logic [lfdc_pkg::SENSOR_W-1:0]         i_sensor_7,
    input  logic [lfdc_pkg::POS_W-1:0]            i_line_position,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [lfdc_pkg::WHEEL_W-1:0]   o_left_speed,
    output logic signed [lfdc_pkg::WHEEL_W-1:0]   o_right_speed,
    output logic                                  o_brake,
    output logic                                  o_line_lost
);

    lfdc_pkg::t_cfg                                 r_cfg;
    lfdc_pkg::t_sensor [lfdc_pkg::SENSOR_NUM-1:0]   w_sensor;
    lfdc_pkg::t_entry                               w_push_entry, w_head;
    lfdc_pkg::t_fifo_status                         w_status;
    logic                                           w_push, w_pop;
    logic [lfdc_pkg::WHEEL_W-1:0]                   w_left, w_right;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_mode     <= '0;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.line_center    <= '0;
            r_cfg.base_speed     <= lfdc_pkg::BASE_SPEED_RST;
            r_cfg.line_threshold <= '0;
            r_cfg.lost_level     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                lfdc_pkg::REG_DRIVE_MODE:
                    r_cfg.drive_mode <= i_cfg_wdata[lfdc_pkg::MODE_W-1:0];
                lfdc_pkg::REG_GAIN_P:
                    r_cfg.gain_p <= i_cfg_wdata[lfdc_pkg::GAIN_W-1:0];
                lfdc_pkg::REG_GAIN_I:
                    r_cfg.gain_i <= i_cfg_wdata[lfdc_pkg::GAIN_W-1:0];
                lfdc_pkg::REG_GAIN_D:
                    r_cfg.gain_d <= i_cfg_wdata[lfdc_pkg::GAIN_W-1:0];
                lfdc_pkg::REG_LINE_CENTER:
                    r_cfg.line_center <= i_cfg_wdata[lfdc_pkg::POS_W-1:0];
                lfdc_pkg::REG_BASE_SPEED:
                    r_cfg.base_speed <= i_cfg_wdata[lfdc_pkg::SPEED_W-1:0];
                lfdc_pkg::REG_LINE_THRESHOLD:
                    r_cfg.line_threshold <= i_cfg_wdata[lfdc_pkg::SENSOR_W-1:0];
                lfdc_pkg::REG_LOST_LEVEL:
                    r_cfg.lost_level <= i_cfg_wdata[lfdc_pkg::SENSOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Gather the sensor bar, leftmost first.
    assign w_sensor[0] = i_sensor_0;
    assign w_sensor[1] = i_sensor_1;
    assign w_sensor[2] = i_sensor_2;
    assign w_sensor[3] = i_sensor_3;
    assign w_sensor[4] = i_sensor_4;
    assign w_sensor[5] = i_sensor_5;
    assign w_sensor[6] = i_sensor_6;
    assign w_sensor[7] = i_sensor_7;

    lfdc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_in_valid),
        .i_sensor        (w_sensor),
        .i_line_position (i_line_position),
        .i_full          (w_status.full),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    lfdc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    lfdc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_left   (w_left),
        .o_right  (w_right),
        .o_brake  (o_brake),
        .o_lost   (o_line_lost)
    );

    assign o_in_stall    = w_status.full;
    assign o_left_speed  = $signed(w_left);
    assign o_right_speed = $signed(w_right);

endmodule
